@@ hdl/qwd_pkg.sv @@
// ----------------------------------------------------------------------------
// qwd_pkg: shared types and constants of the quadrature wheel decoder
// Holds the direction-machine states, phase codes, step values, register
// indexes and the structs passed between the decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package qwd_pkg;

  // Timestamp and interval register width
  localparam int TIME_W = 32;
  // Configuration register index width (two registers)
  localparam int CFG_INDEX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_INTERVAL = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_INTERVAL = 1'b1;

  // Reset values of the interval registers
  localparam logic [TIME_W-1:0] MIN_INTERVAL_RST = TIME_W'(5000);
  localparam logic [TIME_W-1:0] MAX_INTERVAL_RST = TIME_W'(100000);

  // Step values (two's complement)
  localparam logic signed [1:0] STEP_NONE = 2'sb00;
  localparam logic signed [1:0] STEP_FWD  = 2'sb01;
  localparam logic signed [1:0] STEP_BWD  = 2'sb11;

  // Direction machine states
  typedef enum logic [3:0] {
    MODE_STOP     = 4'b0001,
    MODE_TRIGGER  = 4'b0010,
    MODE_FORWARD  = 4'b0100,
    MODE_BACKWARD = 4'b1000
  } mode_t;

  // Which pin an edge belongs to
  typedef enum logic [1:0] {
    PHASE_NONE = 2'd0,
    PHASE_A    = 2'd1,
    PHASE_B    = 2'd2
  } phase_t;

  // One pin sample
  typedef struct packed {
    logic              pin_a;
    logic              pin_b;
    logic [TIME_W-1:0] now;
  } sample_t;

  // Interval registers
  typedef struct packed {
    logic [TIME_W-1:0] min_interval;
    logic [TIME_W-1:0] max_interval;
  } cfg_t;

  // Pin history used by the noise filter
  typedef struct packed {
    logic              prev_a;
    logic              prev_b;
    logic [TIME_W-1:0] time_a;
    logic [TIME_W-1:0] time_b;
    phase_t            last_phase;
  } hist_t;

  // Edge classification of one sample
  typedef struct packed {
    logic chg_a;
    logic chg_b;
    logic noise;
  } edge_t;

endpackage

`default_nettype wire

@@ hdl/qwd_noise.sv @@
// ----------------------------------------------------------------------------
// qwd_noise: edge detect and noise filter
// Flags pin changes of a sample and rejects it when an edge repeats the last
// pin, comes too soon, or when no pin moved and a pin has idled too long.
// ----------------------------------------------------------------------------
`default_nettype none

module qwd_noise (
  input  wire  qwd_pkg::sample_t sample,
  input  wire  qwd_pkg::hist_t   hist,
  input  wire  qwd_pkg::cfg_t    cfg,
  output qwd_pkg::edge_t         edges
);

  logic [qwd_pkg::TIME_W-1:0] da;
  logic [qwd_pkg::TIME_W-1:0] db;
  logic                       chg_a;
  logic                       chg_b;
  logic                       bad_a;
  logic                       bad_b;
  logic                       idle;

  // Elapsed time since the last edge on each pin, modulo 2^TIME_W
  assign da = sample.now - hist.time_a;
  assign db = sample.now - hist.time_b;

  assign chg_a = sample.pin_a != hist.prev_a;
  assign chg_b = sample.pin_b != hist.prev_b;

  // Reject a repeated pin or an edge sooner than the minimum interval
  assign bad_a = chg_a && ((hist.last_phase == qwd_pkg::PHASE_A) || (da < cfg.min_interval));
  assign bad_b = chg_b && ((hist.last_phase == qwd_pkg::PHASE_B) || (db < cfg.min_interval));

  // Reject an unchanged sample after a long idle
  assign idle = (da > cfg.max_interval) || (db > cfg.max_interval);

  always_comb begin
    edges.chg_a = chg_a;
    edges.chg_b = chg_b;
    if (chg_a || chg_b) begin
      edges.noise = bad_a || bad_b;
    end else begin
      edges.noise = idle;
    end
  end

endmodule

`default_nettype wire

@@ hdl/qwd_tracker.sv @@
// ----------------------------------------------------------------------------
// qwd_tracker: pin history and direction machine
// Keeps the pin levels and edge times, runs the stop / trigger / forward /
// backward machine and gives the step of the sample being processed.
// ----------------------------------------------------------------------------
`default_nettype none

module qwd_tracker (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      adv,
  input  wire  qwd_pkg::sample_t   sample,
  input  wire  qwd_pkg::cfg_t      cfg,
  output logic signed [1:0]        step
);

  qwd_pkg::hist_t  hist;
  qwd_pkg::hist_t  hist_next;
  qwd_pkg::mode_t  mode;
  qwd_pkg::mode_t  mode_next;
  qwd_pkg::phase_t trigger_phase;
  qwd_pkg::phase_t trigger_phase_next;
  logic            trigger_level;
  logic            trigger_level_next;
  qwd_pkg::edge_t  edges;
  logic            same;
  logic            edge_fwd;
  logic            moved;

  qwd_noise u_noise (
    .sample (sample),
    .hist   (hist),
    .cfg    (cfg),
    .edges  (edges)
  );

  assign same     = sample.pin_a == sample.pin_b;
  // Direction of a single edge; phase A takes precedence
  assign edge_fwd = edges.chg_a ? same : !same;
  // In a locked direction only the trigger pin counts
  assign moved    = (trigger_phase == qwd_pkg::PHASE_A) ? edges.chg_a : edges.chg_b;

  // Direction machine
  always_comb begin
    mode_next          = mode;
    trigger_phase_next = trigger_phase;
    trigger_level_next = trigger_level;
    step               = qwd_pkg::STEP_NONE;
    if (!edges.noise) begin
      unique case (mode)
        qwd_pkg::MODE_STOP: begin
          if (edges.chg_a) begin
            mode_next          = qwd_pkg::MODE_TRIGGER;
            trigger_phase_next = qwd_pkg::PHASE_A;
            trigger_level_next = sample.pin_a;
          end else if (edges.chg_b) begin
            mode_next          = qwd_pkg::MODE_TRIGGER;
            trigger_phase_next = qwd_pkg::PHASE_B;
            trigger_level_next = sample.pin_b;
          end
        end
        qwd_pkg::MODE_TRIGGER: begin
          if (trigger_phase == qwd_pkg::PHASE_A) begin
            if (sample.pin_a != trigger_level) begin
              mode_next = qwd_pkg::MODE_STOP;
            end else if (same) begin
              mode_next = qwd_pkg::MODE_FORWARD;
              step      = qwd_pkg::STEP_FWD;
            end else begin
              mode_next = qwd_pkg::MODE_BACKWARD;
              step      = qwd_pkg::STEP_BWD;
            end
          end else begin
            if (sample.pin_b != trigger_level) begin
              mode_next = qwd_pkg::MODE_STOP;
            end else if (same) begin
              mode_next = qwd_pkg::MODE_BACKWARD;
              step      = qwd_pkg::STEP_BWD;
            end else begin
              mode_next = qwd_pkg::MODE_FORWARD;
              step      = qwd_pkg::STEP_FWD;
            end
          end
        end
        qwd_pkg::MODE_FORWARD: begin
          if (moved) begin
            if (edge_fwd) begin
              step = qwd_pkg::STEP_FWD;
            end else begin
              mode_next = qwd_pkg::MODE_STOP;
            end
          end
        end
        qwd_pkg::MODE_BACKWARD: begin
          if (moved) begin
            if (!edge_fwd) begin
              step = qwd_pkg::STEP_BWD;
            end else begin
              mode_next = qwd_pkg::MODE_STOP;
            end
          end
        end
        default: begin
          mode_next = qwd_pkg::MODE_STOP;
        end
      endcase
    end
  end

  // Update pin history on every sample, rejected or not
  always_comb begin
    hist_next = hist;
    if (edges.chg_a) begin
      hist_next.last_phase = qwd_pkg::PHASE_A;
      hist_next.prev_a     = sample.pin_a;
      hist_next.time_a     = sample.now;
    end
    if (edges.chg_b) begin
      hist_next.last_phase = qwd_pkg::PHASE_B;
      hist_next.prev_b     = sample.pin_b;
      hist_next.time_b     = sample.now;
    end
  end

  // Advance state once per processed sample
  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= qwd_pkg::MODE_STOP;
      trigger_phase   <= qwd_pkg::PHASE_NONE;
      trigger_level   <= 1'b0;
      hist.prev_a     <= 1'b0;
      hist.prev_b     <= 1'b0;
      hist.time_a     <= '0;
      hist.time_b     <= '0;
      hist.last_phase <= qwd_pkg::PHASE_NONE;
    end else if (adv) begin
      mode          <= mode_next;
      trigger_phase <= trigger_phase_next;
      trigger_level <= trigger_level_next;
      hist          <= hist_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/quadrature_wheel_decoder.sv @@
// ----------------------------------------------------------------------------
// quadrature_wheel_decoder: debounced quadrature wheel to detent steps
//
// Input channel (in_valid / in_stall) carries one sample: pin_a, pin_b and
// a 32-bit timestamp now. Output channel (out_valid / out_stall) carries one
// signed step per sample: +1 forward, -1 backward, 0 none.
// A sample transfer lands in the input register; once the output register is
// free, the noise filter and direction machine evaluate it and the step is
// captured in the output register. Throughput is one sample per cycle while
// the receiver does not stall; the direction machine, fed by two 32-bit
// subtract-and-compare paths, updates its state as the step is captured.
// When the receiver stalls, the output register holds its step and the input
// register holds its sample; in_stall rises only once both are full, so one
// more sample is taken behind a stalled result.
// The user writes the interval registers through cfg_write / cfg_index /
// cfg_data only while no sample is in flight; the block does not enforce it.
// Synchronous reset empties both registers, puts the direction machine in
// stop, clears pin history and loads the default intervals.
// ----------------------------------------------------------------------------
`default_nettype none

module quadrature_wheel_decoder (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_write,
  input  wire  [qwd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire  [qwd_pkg::TIME_W-1:0]         cfg_data,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire                                pin_a,
  input  wire                                pin_b,
  input  wire  [qwd_pkg::TIME_W-1:0]         now,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic signed [1:0]                  step
);

  qwd_pkg::cfg_t    cfg;
  qwd_pkg::sample_t stg;
  logic             stg_valid;
  logic             out_free;
  logic             adv;
  logic             in_take;
  logic signed [1:0] step_calc;

  // Handshake control
  assign out_free = !out_valid || !out_stall;
  assign adv      = stg_valid && out_free;
  assign in_stall = stg_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  // Interval registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_interval <= qwd_pkg::MIN_INTERVAL_RST;
      cfg.max_interval <= qwd_pkg::MAX_INTERVAL_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        qwd_pkg::CFG_MIN_INTERVAL: cfg.min_interval <= cfg_data;
        qwd_pkg::CFG_MAX_INTERVAL: cfg.max_interval <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: load on transfer, drop once processed
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (in_take) begin
      stg_valid <= 1'b1;
    end else if (adv) begin
      stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stg.pin_a <= pin_a;
      stg.pin_b <= pin_b;
      stg.now   <= now;
    end
  end

  qwd_tracker u_tracker (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .sample (stg),
    .cfg    (cfg),
    .step   (step_calc)
  );

  // Output register: capture on advance, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= adv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      step <= step_calc;
    end
  end

endmodule

`default_nettype wire
